// File: hw/rtl/tun_pkg.sv
// Package with the payload types, widths and stage record of the triangle normal pipeline.
`default_nettype none

package tun_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int FIELD_WIDTH      = 16;
    localparam int OUT_WIDTH        = 16;

    // Edge, product, cross-product and square widths.
    localparam int EDW = COORD_WIDTH + 1;
    localparam int PW  = 2 * EDW;
    localparam int XW  = PW + 1;
    localparam int MW  = PW;
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;
    // Bits of the result magnitude, which reaches 2^NORMAL_FRAC_BITS.
    localparam int NB  = NORMAL_FRAC_BITS + 1;
    // Width of the remainder arithmetic in the square-root search.
    localparam int EW  = SW + 2 * NB + 4;
    localparam int RSH = 2 * NORMAL_FRAC_BITS + 2;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] first_x;
        logic signed [FIELD_WIDTH-1:0] first_y;
        logic signed [FIELD_WIDTH-1:0] first_z;
        logic signed [FIELD_WIDTH-1:0] second_x;
        logic signed [FIELD_WIDTH-1:0] second_y;
        logic signed [FIELD_WIDTH-1:0] second_z;
        logic signed [FIELD_WIDTH-1:0] third_x;
        logic signed [FIELD_WIDTH-1:0] third_y;
        logic signed [FIELD_WIDTH-1:0] third_z;
    } tun_in_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] normal_x;
        logic signed [OUT_WIDTH-1:0] normal_y;
        logic signed [OUT_WIDTH-1:0] normal_z;
        logic                        degenerate;
    } tun_out_t;

    // One stage of the bit-by-bit search for the rounded unit components.
    typedef struct packed {
        logic [2:0][EW-1:0] e;
        logic [2:0][EW-1:0] p;
        logic [2:0][NB-1:0] t;
        logic [SW-1:0]      s;
        logic [2:0]         neg;
        logic               deg;
    } tun_it_t;

endpackage

`default_nettype wire

// File: hw/rtl/triangle_unit_normal_unit.sv
// Top level: pipelined unit face normal of one triangle per cycle.
// Throughput: one transaction per cycle while the output is not stalled; each search bit of the root is its own stage.
// Every stage has its own valid bit and stalls only when full and blocked downstream.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
`default_nettype none

module triangle_unit_normal_unit
    import tun_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire tun_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output tun_out_t      out_data
);

    localparam int NV = NB + 6;

    logic [NV-1:0] vld_reg;
    logic [NV-1:0] en;

    always_comb
    begin
        en[NV-1] = !vld_reg[NV-1] || out_ready;
        for (int i = NV - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NV-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NV; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Only the low COORD_WIDTH bits of a field carry the coordinate.
    function automatic logic signed [EDW-1:0] coord(input logic [FIELD_WIDTH-1:0] v);
        return EDW'($signed(v[COORD_WIDTH-1:0]));
    endfunction

    // Stage 1: edges A = first - second, B = first - third.
    logic signed [EDW-1:0] ea_reg [3];
    logic signed [EDW-1:0] eb_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ea_reg[0] <= coord(in_data.first_x) - coord(in_data.second_x);
            ea_reg[1] <= coord(in_data.first_y) - coord(in_data.second_y);
            ea_reg[2] <= coord(in_data.first_z) - coord(in_data.second_z);
            eb_reg[0] <= coord(in_data.first_x) - coord(in_data.third_x);
            eb_reg[1] <= coord(in_data.first_y) - coord(in_data.third_y);
            eb_reg[2] <= coord(in_data.first_z) - coord(in_data.third_z);
        end
    end

    // Stage 2: the six products of the cross product.
    logic signed [PW-1:0] pa_reg [3];
    logic signed [PW-1:0] pb_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            pa_reg[0] <= ea_reg[1] * eb_reg[2];
            pb_reg[0] <= eb_reg[1] * ea_reg[2];
            pa_reg[1] <= eb_reg[0] * ea_reg[2];
            pb_reg[1] <= ea_reg[0] * eb_reg[2];
            pa_reg[2] <= ea_reg[0] * eb_reg[1];
            pb_reg[2] <= eb_reg[0] * ea_reg[1];
        end
    end

    // Stage 3: cross components as sign and magnitude.
    logic [MW-1:0] mag_reg [3];
    logic [2:0]    neg3_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [XW-1:0] c;
                c = XW'(pa_reg[i]) - XW'(pb_reg[i]);
                neg3_reg[i] <= c[XW-1];
                mag_reg[i]  <= c[XW-1] ? MW'(-c) : MW'(c);
            end
        end
    end

    // Stage 4: squared magnitudes.
    logic [SQW-1:0] sq_reg [3];
    logic [2:0]     neg4_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= SQW'(mag_reg[i]) * SQW'(mag_reg[i]);
            end
            neg4_reg <= neg3_reg;
        end
    end

    // Stage 5 seeds the search. With u = 2t - 1, e holds m^2 * 2^(2F+2) - u^2 * s
    // and p holds u * s, starting from t = 0. All of it is modulo 2^EW.
    tun_it_t it_reg [NB+1];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            logic [SW-1:0] s;
            s = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                it_reg[0].e[i] <= (EW'(sq_reg[i]) << RSH) - EW'(s);
                it_reg[0].p[i] <= EW'(0) - EW'(s);
                it_reg[0].t[i] <= '0;
            end
            it_reg[0].s   <= s;
            it_reg[0].neg <= neg4_reg;
            it_reg[0].deg <= (s == '0);
        end
    end

    // One stage per result bit, most significant first. Setting bit b adds
    // d = 2^(b+1) to u, so u^2 s grows by 2dp + d^2 s.
    for (genvar k = 0; k < NB; k++)
    begin : g_bit
        localparam int B = NB - 1 - k;

        always_ff @(posedge clk)
        begin
            if (en[5+k])
            begin
                for (int i = 0; i < 3; i++)
                begin
                    logic [EW-1:0] trial;
                    logic          take;
                    trial = it_reg[k].e[i] - (it_reg[k].p[i] << (B + 2))
                            - (EW'(it_reg[k].s) << (2 * B + 2));
                    // The magnitude never goes past 2^F, so once the top bit is set
                    // no lower bit may join it.
                    take = !trial[EW-1] && !it_reg[k].t[i][NB-1];
                    it_reg[k+1].e[i] <= take ? trial : it_reg[k].e[i];
                    it_reg[k+1].p[i] <= take ? it_reg[k].p[i] + (EW'(it_reg[k].s) << (B + 1))
                                             : it_reg[k].p[i];
                    it_reg[k+1].t[i] <= take ? (it_reg[k].t[i] | NB'(1 << B))
                                             : it_reg[k].t[i];
                end
                it_reg[k+1].s   <= it_reg[k].s;
                it_reg[k+1].neg <= it_reg[k].neg;
                it_reg[k+1].deg <= it_reg[k].deg;
            end
        end
    end

    // Last stage: apply signs; a zero cross product gives a zero normal.
    tun_out_t out_reg;
    tun_out_t out_next;

    always_comb
    begin
        logic [2:0][OUT_WIDTH-1:0] comp;
        for (int i = 0; i < 3; i++)
        begin
            comp[i] = it_reg[NB].neg[i] ? OUT_WIDTH'(0) - OUT_WIDTH'(it_reg[NB].t[i])
                                        : OUT_WIDTH'(it_reg[NB].t[i]);
            if (it_reg[NB].deg)
            begin
                comp[i] = '0;
            end
        end
        out_next.normal_x   = comp[0];
        out_next.normal_y   = comp[1];
        out_next.normal_z   = comp[2];
        out_next.degenerate = it_reg[NB].deg;
    end

    always_ff @(posedge clk)
    begin
        if (en[NV-1])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tun_checker.sv
// Port-level checker for the triangle normal unit, bound to the top level.
`default_nettype none

module tun_checker
    import tun_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_ready,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire tun_out_t out_data
);

    localparam logic signed [OUT_WIDTH-1:0] ONE = OUT_WIDTH'(1 << NORMAL_FRAC_BITS);

    // A result held back by the consumer must not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    // A degenerate triangle reports an all-zero normal.
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
            out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
        else $error("degenerate result with nonzero normal");

    // Components stay within plus or minus one.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.normal_x <= ONE && out_data.normal_x >= -ONE
                   && out_data.normal_y <= ONE && out_data.normal_y >= -ONE
                   && out_data.normal_z <= ONE && out_data.normal_z >= -ONE)
        else $error("normal component out of range");

    // With the output free, the pipeline must take new input.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input refused while output is free");

    // A non-degenerate normal cannot be all zero.
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.degenerate |->
            out_data.normal_x != '0 || out_data.normal_y != '0 || out_data.normal_z != '0)
        else $error("zero normal without degenerate flag");

endmodule

bind triangle_unit_normal_unit tun_checker u_tun_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
